[sv/iee_pkg.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// iee_pkg
// Shared constants, character codes and precedence lookup for the infix
// expression evaluator.
// -----------------------------------------------------------------------------
package iee_pkg;

   localparam int DATA_W          = 32;
   localparam int OP_DEPTH_DEF    = 64;
   localparam int VALUE_DEPTH_DEF = 64;

   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_ZERO   = 8'h30;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_UNDER = 2'd1;
   localparam logic [1:0] ST_OVER  = 2'd2;

   typedef logic [DATA_W-1:0] word_type;

   function automatic logic [2:0] rank_of(input logic [7:0] op);
      logic [2:0] r;
      case (op) inside
         CH_LPAREN:          r = 3'd1;
         CH_PLUS, CH_MINUS:  r = 3'd2;
         CH_STAR, CH_SLASH:  r = 3'd3;
         CH_CARET:           r = 3'd4;
         default:            r = 3'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

[sv/infix_expression_evaluator.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// infix_expression_evaluator
// Two-stack infix evaluator: characters in, one result per expression out.
// -----------------------------------------------------------------------------
// Usage:
//   req_* carries one expression character per item; req_tlast marks the
//   final character. rsp_* carries one item per expression: the 32-bit result
//   and a status code (ok, underflow, overflow).
//   Operator and value stacks live in two single-port-read synchronous RAMs.
//   A digit or '(' is taken in the idle state. An operator or ')' scans the
//   operator stack and runs a reduction (pop two values, compute, push) for
//   every operator it pops, and the scan stops at a stacked '(' or a
//   lower-ranked operator; a division runs in the bit-serial divider. The
//   final character reduces all stacked operators before the result item is presented.
//   The result sits in an output register; the next expression is accepted
//   while it waits, and the block only stalls once a second result is ready
//   and rsp_tready is still low.
//   Reset empties both stacks, clears the error flags and drops rsp_tvalid.
//   No clearing pass is needed; stack entries above the counts are never read.
// -----------------------------------------------------------------------------
module infix_expression_evaluator
   import iee_pkg::*;
#(
   parameter int OP_STACK_DEPTH    = OP_DEPTH_DEF,
   parameter int VALUE_STACK_DEPTH = VALUE_DEPTH_DEF
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_code
   input  wire logic        req_tlast,   // last_char
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // [31:0] result_value, [33:32] status
);

   localparam int OCW = $clog2(OP_STACK_DEPTH + 1);
   localparam int OIW = $clog2(OP_STACK_DEPTH);
   localparam int VCW = $clog2(VALUE_STACK_DEPTH + 1);
   localparam int VIW = $clog2(VALUE_STACK_DEPTH);
   localparam logic [OCW-1:0] OP_FULL = OCW'(OP_STACK_DEPTH);
   localparam logic [VCW-1:0] V_FULL  = VCW'(VALUE_STACK_DEPTH);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_LOOP   = 4'd1;
   localparam logic [3:0] S_CHK    = 4'd2;
   localparam logic [3:0] S_RHS    = 4'd3;
   localparam logic [3:0] S_LHS    = 4'd4;
   localparam logic [3:0] S_ALU    = 4'd5;
   localparam logic [3:0] S_DIV    = 4'd6;
   localparam logic [3:0] S_PUSH   = 4'd7;
   localparam logic [3:0] S_RESULT = 4'd8;
   localparam logic [3:0] S_OUT    = 4'd9;

   localparam logic [1:0] M_CLOSE = 2'd0;
   localparam logic [1:0] M_OPER  = 2'd1;
   localparam logic [1:0] M_FINAL = 2'd2;

   localparam int F_UNDER = 0;
   localparam int F_OVER  = 1;

   logic [3:0]     state_ff, state_in;
   logic [1:0]     mode_ff, mode_in;
   logic [7:0]     char_ff, char_in;
   logic           last_ff, last_in;
   logic [OCW-1:0] opcnt_ff, opcnt_in;
   logic [VCW-1:0] vcnt_ff, vcnt_in;
   logic [1:0]     flags_ff, flags_in;
   logic [7:0]     opcode_ff, opcode_in;
   word_type       rhs_ff, rhs_in;
   word_type       lhs_ff, lhs_in;
   word_type       res_ff, res_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [39:0]    rsp_data_ff, rsp_data_in;

   logic [7:0]     op_mem [OP_STACK_DEPTH];
   logic           op_we;
   logic [OIW-1:0] op_wa;
   logic [7:0]     op_wd;
   logic [OIW-1:0] op_ra;
   logic [7:0]     op_rd_ff;

   word_type       v_mem [VALUE_STACK_DEPTH];
   logic           v_we;
   logic [VIW-1:0] v_wa;
   word_type       v_wd;
   logic [VIW-1:0] v_ra;
   word_type       v_rd_ff;

   logic           div_start;
   logic           div_done;
   word_type       div_quo;
   logic           accept;
   logic [1:0]     fin_flags;

   iee_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (lhs_ff),
      .divisor  (rhs_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign fin_flags  = flags_ff | ((vcnt_ff == '0) ? 2'b01 : 2'b00);

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      opcnt_in     = opcnt_ff;
      vcnt_in      = vcnt_ff;
      flags_in     = flags_ff;
      opcode_in    = opcode_ff;
      rhs_in       = rhs_ff;
      lhs_in       = lhs_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      op_we        = 1'b0;
      op_wa        = opcnt_ff[OIW-1:0];
      op_wd        = char_ff;
      op_ra        = OIW'(opcnt_ff - OCW'(1));
      v_we         = 1'b0;
      v_wa         = vcnt_ff[VIW-1:0];
      v_wd         = res_ff;
      v_ra         = VIW'(vcnt_ff - VCW'(1));
      div_start    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               char_in = req_tdata;
               last_in = req_tlast;
               state_in = req_tlast ? S_LOOP : S_IDLE;
               mode_in  = M_FINAL;
               unique case (req_tdata) inside
                  CH_LPAREN: begin
                     if (opcnt_ff >= OP_FULL) begin
                        flags_in[F_OVER] = 1'b1;
                     end else begin
                        op_we    = 1'b1;
                        op_wd    = req_tdata;
                        opcnt_in = opcnt_ff + OCW'(1);
                     end
                  end
                  CH_RPAREN: begin
                     mode_in  = M_CLOSE;
                     state_in = S_LOOP;
                  end
                  CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET: begin
                     mode_in  = M_OPER;
                     state_in = S_LOOP;
                  end
                  default: begin
                     if (vcnt_ff >= V_FULL) begin
                        flags_in[F_OVER] = 1'b1;
                     end else begin
                        v_we    = 1'b1;
                        v_wd    = {24'd0, req_tdata} - {24'd0, CH_ZERO};
                        vcnt_in = vcnt_ff + VCW'(1);
                     end
                  end
               endcase
            end
         end
         S_LOOP: begin
            if (opcnt_ff == '0) begin
               mode_in  = M_FINAL;
               state_in = last_ff ? S_LOOP : S_IDLE;
               unique case (mode_ff)
                  M_CLOSE: flags_in[F_UNDER] = 1'b1;
                  M_OPER: begin
                     op_we    = 1'b1;
                     opcnt_in = OCW'(1);
                  end
                  default: state_in = S_RESULT;
               endcase
            end else begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            opcode_in = op_rd_ff;
            opcnt_in  = opcnt_ff - OCW'(1);
            state_in  = S_RHS;
            if (mode_ff == M_CLOSE && op_rd_ff == CH_LPAREN) begin
               mode_in  = M_FINAL;
               state_in = last_ff ? S_LOOP : S_IDLE;
            end else if (mode_ff == M_OPER && rank_of(op_rd_ff) < rank_of(char_ff)) begin
               opcnt_in = opcnt_ff;
               mode_in  = M_FINAL;
               state_in = last_ff ? S_LOOP : S_IDLE;
               if (opcnt_ff >= OP_FULL) begin
                  flags_in[F_OVER] = 1'b1;
               end else begin
                  op_we    = 1'b1;
                  opcnt_in = opcnt_ff + OCW'(1);
               end
            end
         end
         S_RHS: begin
            state_in = S_LHS;
            v_ra     = VIW'(vcnt_ff - VCW'(2));
            if (vcnt_ff != '0) begin
               rhs_in  = v_rd_ff;
               vcnt_in = vcnt_ff - VCW'(1);
            end else begin
               rhs_in = '0;
               flags_in[F_UNDER] = 1'b1;
            end
         end
         S_LHS: begin
            state_in = S_ALU;
            if (vcnt_ff != '0) begin
               lhs_in  = v_rd_ff;
               vcnt_in = vcnt_ff - VCW'(1);
            end else begin
               lhs_in = '0;
               flags_in[F_UNDER] = 1'b1;
            end
         end
         S_ALU: begin
            state_in = S_PUSH;
            case (opcode_ff)
               CH_PLUS:  res_in = lhs_ff + rhs_ff;
               CH_MINUS: res_in = lhs_ff - rhs_ff;
               CH_STAR:  res_in = lhs_ff * rhs_ff;
               CH_CARET: res_in = lhs_ff ^ rhs_ff;
               CH_SLASH: begin
                  res_in = '0;
                  if (!rhs_ff[DATA_W-1] && rhs_ff != '0) begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
               default:  res_in = '1;
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               res_in   = div_quo;
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            state_in = S_LOOP;
            if (vcnt_ff >= V_FULL) begin
               flags_in[F_OVER] = 1'b1;
            end else begin
               v_we    = 1'b1;
               vcnt_in = vcnt_ff + VCW'(1);
            end
         end
         S_RESULT: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in[31:0]  = (vcnt_ff == '0) ? '0 : v_rd_ff;
               rsp_data_in[33:32] = fin_flags[F_OVER]  ? ST_OVER :
                                    fin_flags[F_UNDER] ? ST_UNDER : ST_OK;
               rsp_data_in[39:34] = '0;
               opcnt_in = '0;
               vcnt_in  = '0;
               flags_in = '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= M_FINAL;
         opcnt_ff     <= '0;
         vcnt_ff      <= '0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         opcnt_ff     <= opcnt_in;
         vcnt_ff      <= vcnt_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      char_ff     <= char_in;
      last_ff     <= last_in;
      opcode_ff   <= opcode_in;
      rhs_ff      <= rhs_in;
      lhs_ff      <= lhs_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (op_we) begin
         op_mem[op_wa] <= op_wd;
      end
      op_rd_ff <= op_mem[op_ra];
   end

   always_ff @(posedge clock) begin
      if (v_we) begin
         v_mem[v_wa] <= v_wd;
      end
      v_rd_ff <= v_mem[v_ra];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

[sv/iee_div.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// iee_div
// Radix-2 restoring divider: signed dividend by positive divisor, quotient
// truncated toward zero, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module iee_div
   import iee_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire word_type dividend,
   input  wire word_type divisor,
   output logic          done,
   output word_type      quotient
);

   localparam int CNT_W = $clog2(DATA_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   word_type         rem_ff, rem_in;
   word_type         quo_ff, quo_in;
   word_type         den_ff, den_in;
   logic             neg_ff, neg_in;
   logic [DATA_W:0]  shifted;
   logic [DATA_W:0]  diff;
   logic             fits;

   assign shifted = {rem_ff, quo_ff[DATA_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = ~diff[DATA_W];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend[DATA_W-1] ? (~dividend + word_type'(1)) : dividend;
         den_in  = divisor;
         neg_in  = dividend[DATA_W-1];
      end else if (busy_ff) begin
         rem_in = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
         quo_in = {quo_ff[DATA_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + word_type'(1)) : quo_ff;

endmodule
`default_nettype wire

[dv/tb_infix_expression_evaluator.sv]
// -----------------------------------------------------------------------------
// tb_infix_expression_evaluator
// Streams expression characters into the evaluator and checks every result
// item against an operator/value stack predictor running alongside (typed rows
// use their table result). A short directed table covers the character extremes,
// each operator and the underflow paths. Random well-formed, broken, noisy and
// stack-flooding expressions follow, with random gaps and stalls on both channels.
// -----------------------------------------------------------------------------
module tb_infix_expression_evaluator;
   import iee_pkg::*;

   localparam int RANDOM_ITEMS   = 500;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 200;
   localparam int MAX_REPORTS    = 10;
   localparam int UNDER_BIT      = 0;
   localparam int OVER_BIT       = 1;
   localparam int N_DIRECTED     = 22;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] value;
   } outcome_type;

   typedef struct packed {
      logic [7:0]  ch;
      logic        last;
      logic        typed;
      logic [31:0] value;
      logic [1:0]  status;
   } directed_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   always #5 clock = ~clock;

   infix_expression_evaluator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // typed rows: value readable directly from the character sequence
   directed_row_type directed_rows [N_DIRECTED] = '{
      '{8'h00,           1'b1, 1'b1, 32'hFFFF_FFD0, ST_OK},
      '{8'hFF,           1'b1, 1'b1, 32'd207,       ST_OK},
      '{CH_RPAREN,       1'b1, 1'b1, 32'd0,         ST_UNDER},
      '{CH_LPAREN,       1'b1, 1'b1, 32'hFFFF_FFFF, ST_UNDER},
      '{CH_PLUS,         1'b1, 1'b1, 32'd0,         ST_UNDER},
      '{CH_ZERO + 8'd9,  1'b0, 1'b0, 32'd0,         ST_OK},
      '{CH_PLUS,         1'b0, 1'b0, 32'd0,         ST_OK},
      '{CH_ZERO + 8'd8,  1'b1, 1'b0, 32'd0,         ST_OK},
      '{CH_ZERO + 8'd8,  1'b0, 1'b0, 32'd0,         ST_OK},
      '{CH_SLASH,        1'b0, 1'b0, 32'd0,         ST_OK},
      '{CH_ZERO,         1'b1, 1'b1, 32'd0,         ST_OK},
      '{CH_LPAREN,       1'b0, 1'b0, 32'd0,         ST_OK},
      '{CH_ZERO + 8'd1,  1'b0, 1'b0, 32'd0,         ST_OK},
      '{CH_MINUS,        1'b0, 1'b0, 32'd0,         ST_OK},
      '{CH_ZERO + 8'd8,  1'b0, 1'b0, 32'd0,         ST_OK},
      '{CH_RPAREN,       1'b0, 1'b0, 32'd0,         ST_OK},
      '{CH_SLASH,        1'b0, 1'b0, 32'd0,         ST_OK},
      '{CH_ZERO + 8'd2,  1'b0, 1'b0, 32'd0,         ST_OK},
      '{CH_CARET,        1'b0, 1'b0, 32'd0,         ST_OK},
      '{CH_ZERO + 8'd3,  1'b0, 1'b0, 32'd0,         ST_OK},
      '{CH_STAR,         1'b0, 1'b0, 32'd0,         ST_OK},
      '{CH_ZERO + 8'd2,  1'b1, 1'b0, 32'd0,         ST_OK}
   };

   logic [7:0] binary_ops [5] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};

   // evaluator shadow state
   logic [7:0]  opr_stack [OP_DEPTH_DEF];
   logic [31:0] val_stack [VALUE_DEPTH_DEF];
   int unsigned opr_cnt  = 0;
   int unsigned val_cnt  = 0;
   logic [1:0]  err_bits = 2'b00;

   outcome_type pending_results [$];
   logic [7:0]  expr_chars [$];
   int unsigned sent_count  = 0;
   int unsigned expr_count  = 0;
   int unsigned checked     = 0;
   int unsigned n_ok        = 0;
   int unsigned n_under     = 0;
   int unsigned n_over      = 0;
   int unsigned errors      = 0;
   int unsigned idle_cycles = 0;

   function automatic logic [2:0] precedence(input logic [7:0] c);
      case (c)
         CH_LPAREN:         return 3'd1;
         CH_PLUS, CH_MINUS: return 3'd2;
         CH_STAR, CH_SLASH: return 3'd3;
         CH_CARET:          return 3'd4;
         default:           return 3'd0;
      endcase
   endfunction

   function automatic logic [31:0] combine(input logic [7:0] op, input logic [31:0] a,
                                           input logic [31:0] b);
      case (op)
         CH_PLUS:  return a + b;
         CH_MINUS: return a - b;
         CH_STAR:  return a * b;
         CH_SLASH: begin
            if ($signed(b) > 0) return $signed(a) / $signed(b);
            return 32'd0;
         end
         CH_CARET: return a ^ b;
         default:  return 32'hFFFF_FFFF;   // leftover open paren
      endcase
   endfunction

   function automatic void push_value(input logic [31:0] v);
      if (val_cnt >= VALUE_DEPTH_DEF) begin
         err_bits[OVER_BIT] = 1'b1;
      end else begin
         val_stack[val_cnt] = v;
         val_cnt++;
      end
   endfunction

   function automatic logic [31:0] pop_value();
      if (val_cnt == 0) begin
         err_bits[UNDER_BIT] = 1'b1;
         return 32'd0;
      end
      val_cnt--;
      return val_stack[val_cnt];
   endfunction

   function automatic void push_operator(input logic [7:0] op);
      if (opr_cnt >= OP_DEPTH_DEF) begin
         err_bits[OVER_BIT] = 1'b1;
      end else begin
         opr_stack[opr_cnt] = op;
         opr_cnt++;
      end
   endfunction

   function automatic void fold_top();
      logic [7:0]  op;
      logic [31:0] rhs;
      logic [31:0] lhs;
      opr_cnt--;
      op  = opr_stack[opr_cnt];
      rhs = pop_value();
      lhs = pop_value();
      push_value(combine(op, lhs, rhs));
   endfunction

   // advance the shadow evaluator by one character; returns 1 when a result is due
   function automatic bit digest(input logic [7:0] c, input logic last,
                                 output outcome_type res);
      logic [2:0] r;
      res = '0;
      r = precedence(c);
      if (c == CH_LPAREN) begin
         push_operator(c);
      end else if (c == CH_RPAREN) begin
         while (opr_cnt > 0 && opr_stack[opr_cnt-1] != CH_LPAREN) fold_top();
         if (opr_cnt == 0) err_bits[UNDER_BIT] = 1'b1;
         else opr_cnt--;
      end else if (r != 3'd0) begin
         while (opr_cnt > 0 && precedence(opr_stack[opr_cnt-1]) >= r) fold_top();
         push_operator(c);
      end else begin
         push_value({24'd0, c} - {24'd0, CH_ZERO});
      end
      if (!last) return 1'b0;
      while (opr_cnt > 0) fold_top();
      if (val_cnt == 0) begin
         err_bits[UNDER_BIT] = 1'b1;
         res.value = 32'd0;
      end else begin
         res.value = val_stack[val_cnt-1];
      end
      if (err_bits[OVER_BIT]) res.status = ST_OVER;
      else if (err_bits[UNDER_BIT]) res.status = ST_UNDER;
      else res.status = ST_OK;
      opr_cnt  = 0;
      val_cnt  = 0;
      err_bits = 2'b00;
      return 1'b1;
   endfunction

   // every fourth stretch of 40 items runs without idling
   function automatic int unsigned draw_wait(input int unsigned seq);
      if ((seq / 40) % 4 == 3) return 0;
      return $urandom_range(0, 6);
   endfunction

   function automatic logic [7:0] operand_char();
      logic [7:0] c;
      if ($urandom_range(0, 9) != 0) return CH_ZERO + 8'($urandom_range(0, 9));
      do c = 8'($urandom_range(0, 255));
      while (precedence(c) != 3'd0 || c == CH_RPAREN);
      return c;
   endfunction

   function automatic logic [7:0] any_char();
      case ($urandom_range(0, 2))
         0:       return binary_ops[$urandom_range(0, 4)];
         1:       return $urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic build_expression();
      int unsigned kind;
      int unsigned n;
      int unsigned depth;
      int unsigned i;
      expr_chars.delete();
      kind  = $urandom_range(0, 99);
      depth = 0;
      if (kind < 74) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
         for (i = 0; i < n; i++) begin
            while (depth < 6 && $urandom_range(0, 3) == 0) begin
               expr_chars.push_back(CH_LPAREN);
               depth++;
            end
            expr_chars.push_back(operand_char());
            if (depth > 0 && $urandom_range(0, 2) == 0) begin
               expr_chars.push_back(CH_RPAREN);
               depth--;
            end
            if (i + 1 < n) expr_chars.push_back(binary_ops[$urandom_range(0, 4)]);
         end
         for (i = 0; i < depth; i++) expr_chars.push_back(CH_RPAREN);
         // broken variant: one character replaced
         if (kind >= 62) expr_chars[$urandom_range(0, expr_chars.size() - 1)] = any_char();
      end else if (kind < 88) begin
         n = $urandom_range(1, 8);
         for (i = 0; i < n; i++) expr_chars.push_back(any_char());
      end else if (kind < 94) begin
         n = $urandom_range(60, 68);
         for (i = 0; i < n; i++) expr_chars.push_back(operand_char());
      end else begin
         n = $urandom_range(60, 68);
         for (i = 0; i < n; i++) expr_chars.push_back(CH_LPAREN);
         expr_chars.push_back(operand_char());
      end
   endtask

   task automatic send_char(input logic [7:0] c, input logic last, input logic typed,
                            input outcome_type typed_res);
      int unsigned gap;
      outcome_type res;
      gap = draw_wait(sent_count);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (digest(c, last, res)) begin
         if (typed) res = typed_res;
         pending_results.push_back(res);
         expr_count++;
      end
      sent_count++;
      @(negedge clock);
   endtask

   task automatic flag_error(input string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("ERROR: %s", what);
   endtask

   initial begin : stimulus
      outcome_type want;
      int unsigned k;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      for (k = 0; k < N_DIRECTED; k++) begin
         want.value  = directed_rows[k].value;
         want.status = directed_rows[k].status;
         send_char(directed_rows[k].ch, directed_rows[k].last, directed_rows[k].typed, want);
      end
      while (sent_count < N_DIRECTED + RANDOM_ITEMS) begin
         build_expression();
         for (k = 0; k < expr_chars.size(); k++)
            send_char(expr_chars[k], k + 1 == expr_chars.size(), 1'b0, '0);
      end
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d characters in %0d expressions with random gaps and stalls.",
               sent_count, expr_count);
      $display("%0d results checked (%0d ok, %0d underflow, %0d overflow).",
               checked, n_ok, n_under, n_over);
      if (errors == 0) begin
         $display("tb_infix_expression_evaluator passed");
      end else begin
         $display("%0d mismatches", errors);
         $display("tb_infix_expression_evaluator failed");
      end
      $finish;
   end

   initial begin : result_sink
      int unsigned stall;
      outcome_type want;
      while (reset) @(negedge clock);
      forever begin
         stall = draw_wait(checked);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         if (pending_results.size() == 0) begin
            flag_error($sformatf("unexpected result item: value %0d status %0d",
                                 $signed(rsp_tdata[31:0]), rsp_tdata[33:32]));
         end else begin
            want = pending_results.pop_front();
            if (want.value !== rsp_tdata[31:0] || want.status !== rsp_tdata[33:32])
               flag_error($sformatf(
                  "result %0d: expected value %0d status %0d, got value %0d status %0d",
                  checked, $signed(want.value), want.status,
                  $signed(rsp_tdata[31:0]), rsp_tdata[33:32]));
            if (want.status == ST_OVER) n_over++;
            else if (want.status == ST_UNDER) n_under++;
            else n_ok++;
         end
         checked++;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", idle_cycles);
         $display("tb_infix_expression_evaluator failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

[infix_expression_evaluator.f]
sv/iee_pkg.sv
sv/iee_div.sv
sv/infix_expression_evaluator.sv
dv/tb_infix_expression_evaluator.sv
